// ----- hw/rtl/sorted_array_search_queue_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SORTED_ARRAY_SEARCH_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_SEARCH_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/saq_pkg.sv -----
package saq_pkg;

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_REMOVE_MIN = 2'd1,
		OP_SEARCH     = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 7;
	localparam int CAP_W  = 7;

	localparam logic [CFG_IW-1:0] REG_CAPACITY    = 1'd0;
	localparam logic [CFG_IW-1:0] REG_SEARCH_MODE = 1'd1;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic MODE_SEQ = 1'b0;
	localparam logic MODE_BIN = 1'b1;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

	// search unit completion
	typedef struct packed {
		logic done;
		logic hit;
	} srch_res_t;

endpackage

// ----- hw/rtl/saq_if.sv -----
interface saq_in_if #(
	parameter int VW = 32
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           operation;
	logic signed [VW-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface saq_out_if #(
	parameter int VW = 32,
	parameter int PW = 6,
	parameter int CW = 7
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic signed [VW-1:0] removed_value;
	logic [PW-1:0]        position;
	logic [CW-1:0]        count;
	logic signed [VW-1:0] smallest;

	modport source (output valid, output status, output removed_value, output position,
		output count, output smallest, input ready);
	modport sink   (input valid, input status, input removed_value, input position,
		input count, input smallest, output ready);
endinterface

// ----- hw/rtl/saq_cell.sv -----
module saq_cell #(
	parameter int VW = 32
) (
	input  logic                 clk,
	input  saq_pkg::cell_ctl_t   ctl,
	input  logic signed [VW-1:0] key,
	input  logic                 in_use,
	input  logic                 at_end,
	input  logic                 left_gt,
	input  logic signed [VW-1:0] left_val,
	input  logic signed [VW-1:0] right_val,
	output logic signed [VW-1:0] val,
	output logic signed [VW-1:0] val_nxt,
	output logic                 gt,
	output logic                 eq,
	output logic                 lt
);

	logic signed [VW-1:0] val_q;

	assign gt = in_use && (val_q > key);
	assign eq = in_use && (val_q == key);
	assign lt = in_use && (val_q < key);

	// insert: shift right where left neighbor is larger, drop key at the boundary; remove: shift left
	always_comb begin
		val_nxt = val_q;
		if (ctl.ins) begin
			if (left_gt)
				val_nxt = left_val;
			else if (gt || at_end)
				val_nxt = key;
		end else if (ctl.rem) begin
			val_nxt = right_val;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	assign val = val_q;

endmodule

// ----- hw/rtl/saq_search.sv -----
module saq_search #(
	parameter int DEPTH = 64,
	parameter int PW    = 6,
	parameter int CW    = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 mode,
	input  logic [CW-1:0]        count,
	input  logic [DEPTH-1:0]     eq,
	input  logic [DEPTH-1:0]     lt,
	output saq_pkg::srch_res_t   res,
	output logic [PW-1:0]        pos
);

	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		SR_IDLE = 2'b01,
		SR_RUN  = 2'b10
	} srch_state_t;

	srch_state_t          state_q;
	logic                 mode_q;
	logic [DEPTH-1:0]     eq_q;
	logic [DEPTH-1:0]     lt_q;
	logic signed [SW-1:0] lo_q;
	logic signed [SW-1:0] hi_q;

	logic signed [SW-1:0] diff;
	logic signed [SW-1:0] mid;
	logic [PW-1:0]        idx;
	logic                 in_range;
	logic                 probe_eq;
	logic [PW-1:0]        seq_pos;
	logic                 seq_hit;

	// first equal entry; entries are sorted so this is also the early-stop answer
	always_comb begin
		seq_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (eq_q[i])
				seq_pos = PW'(i);
		end
	end
	assign seq_hit = |eq_q;

	assign in_range = (lo_q <= hi_q);
	assign diff     = hi_q - lo_q;
	assign mid      = lo_q + (diff >>> 1);
	assign idx      = mid[PW-1:0];
	assign probe_eq = eq_q[idx];

	always_comb begin
		res.done = 1'b0;
		res.hit  = 1'b0;
		pos      = '0;
		if (state_q == SR_RUN) begin
			if (mode_q == saq_pkg::MODE_SEQ) begin
				res.done = 1'b1;
				res.hit  = seq_hit;
				pos      = seq_pos;
			end else begin
				res.done = !in_range || probe_eq;
				res.hit  = in_range && probe_eq;
				pos      = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
		end else begin
			case (state_q)
				SR_IDLE: if (start) state_q <= SR_RUN;
				SR_RUN:  if (res.done) state_q <= SR_IDLE;
				default: state_q <= SR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			eq_q   <= eq;
			lt_q   <= lt;
			mode_q <= mode;
			lo_q   <= '0;
			hi_q   <= $signed({1'b0, count}) - SW'(1);
		end else if (state_q == SR_RUN && !res.done) begin
			if (lt_q[idx])
				lo_q <= mid + SW'(1);
			else
				hi_q <= mid - SW'(1);
		end
	end

endmodule

// ----- hw/rtl/sorted_array_search_queue.sv -----
// Sorted store: a chain of compare-and-shift cells, one value per cell.
// Insert, remove-min and clear load their result item into the output register at accept.
// Search: the flags are registered at accept; first-match mode answers from them at once,
// binary mode makes one probe per cycle until a hit or an empty range; input is held off meanwhile.
// Throughput: 1 item per cycle for insert, remove-min and clear while the output is not stalled.
// Reset (async, active low): count 0, capacity 64, first-match mode; cells not cleared.
module sorted_array_search_queue #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [saq_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [saq_pkg::CFG_DW-1:0]  cfg_data,
	saq_in_if.sink                      in_ch,
	saq_out_if.source                   out_ch
);

	localparam int VW   = VALUE_WIDTH;
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > saq_pkg::CAP_W) ? CW : saq_pkg::CAP_W;

	typedef enum logic [1:0] {
		T_IDLE = 2'b01,
		T_SRCH = 2'b10
	} top_state_t;

	// ---------------------------------------------------------------- config
	logic [saq_pkg::CAP_W-1:0] cap_q;
	logic                      mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= saq_pkg::CAP_RESET;
			mode_q <= saq_pkg::MODE_SEQ;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				saq_pkg::REG_CAPACITY:    cap_q  <= cfg_data[saq_pkg::CAP_W-1:0];
				saq_pkg::REG_SEARCH_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- control
	top_state_t     state_q;
	logic [CW-1:0]  count_q;
	logic           accept;
	saq_pkg::op_t   op;
	logic           full;
	logic           empty;
	logic           srch_start;
	saq_pkg::cell_ctl_t ctl;
	saq_pkg::srch_res_t srch_res;
	logic [PW-1:0]  srch_pos;
	logic [CW-1:0]  count_nxt;

	// output register
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic signed [VW-1:0] out_removed_q;
	logic [PW-1:0]        out_pos_q;
	logic [CW-1:0]        out_count_q;
	logic signed [VW-1:0] out_small_q;

	assign in_ch.ready = (state_q == T_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;
	assign op          = saq_pkg::op_t'(in_ch.operation);

	// capacity zero acts as one, above DEPTH acts as DEPTH
	assign full = (count_q >= CW'(DEPTH))
		|| ((cap_q != '0) && (CMPW'(count_q) >= CMPW'(cap_q)))
		|| ((cap_q == '0) && (count_q != '0));
	assign empty = (count_q == '0);

	assign ctl.ins    = accept && (op == saq_pkg::OP_INSERT) && !full;
	assign ctl.rem    = accept && (op == saq_pkg::OP_REMOVE_MIN) && !empty;
	assign srch_start = accept && (op == saq_pkg::OP_SEARCH);

	always_comb begin
		count_nxt = count_q;
		if (accept) begin
			case (op)
				saq_pkg::OP_INSERT:     if (!full) count_nxt = count_q + CW'(1);
				saq_pkg::OP_REMOVE_MIN: if (!empty) count_nxt = count_q - CW'(1);
				saq_pkg::OP_CLEAR:      count_nxt = '0;
				default:                count_nxt = count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
			case (state_q)
				T_IDLE:  if (srch_start) state_q <= T_SRCH;
				T_SRCH:  if (srch_res.done) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- cell chain
	logic signed [VW-1:0] cell_val [DEPTH];
	logic signed [VW-1:0] cell_nxt [DEPTH];
	logic [DEPTH-1:0]     gt_v;
	logic [DEPTH-1:0]     eq_v;
	logic [DEPTH-1:0]     lt_v;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 left_gt;
		logic signed [VW-1:0] left_val;
		logic signed [VW-1:0] right_val;

		if (i == 0) begin : g_head
			assign left_gt  = 1'b0;
			assign left_val = in_ch.value;
		end else begin : g_mid
			assign left_gt  = gt_v[i-1];
			assign left_val = cell_val[i-1];
		end

		// last cell has no right neighbor; a removed slot there is never read
		if (i == DEPTH - 1) begin : g_tail
			assign right_val = cell_val[i];
		end else begin : g_body
			assign right_val = cell_val[i+1];
		end

		saq_cell #(
			.VW (VW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (in_ch.value),
			.in_use    (count_q > CW'(i)),
			.at_end    (count_q == CW'(i)),
			.left_gt   (left_gt),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.val_nxt   (cell_nxt[i]),
			.gt        (gt_v[i]),
			.eq        (eq_v[i]),
			.lt        (lt_v[i])
		);
	end

	// ---------------------------------------------------------------- search
	saq_search #(
		.DEPTH (DEPTH),
		.PW    (PW),
		.CW    (CW)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (srch_start),
		.mode   (mode_q),
		.count  (count_q),
		.eq     (eq_v),
		.lt     (lt_v),
		.res    (srch_res),
		.pos    (srch_pos)
	);

	// ---------------------------------------------------------------- result
	logic load_now;
	assign load_now = accept && (op != saq_pkg::OP_SEARCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_now || srch_res.done)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_now) begin
			out_pos_q   <= '0;
			out_count_q <= count_nxt;
			// minimum after the op comes straight from the head cell's next value
			out_small_q <= (count_nxt != '0) ? cell_nxt[0] : '0;
			case (op)
				saq_pkg::OP_INSERT: begin
					out_status_q  <= full ? saq_pkg::ST_FULL : saq_pkg::ST_OK;
					out_removed_q <= '0;
				end
				saq_pkg::OP_REMOVE_MIN: begin
					out_status_q  <= empty ? saq_pkg::ST_EMPTY : saq_pkg::ST_OK;
					out_removed_q <= empty ? '0 : cell_val[0];
				end
				default: begin
					out_status_q  <= saq_pkg::ST_OK;
					out_removed_q <= '0;
				end
			endcase
		end else if (srch_res.done) begin
			out_status_q  <= srch_res.hit ? saq_pkg::ST_OK : saq_pkg::ST_NOT_FOUND;
			out_removed_q <= '0;
			out_pos_q     <= srch_res.hit ? srch_pos : '0;
			out_count_q   <= count_q;
			out_small_q   <= empty ? '0 : cell_val[0];
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.removed_value = out_removed_q;
	assign out_ch.position      = out_pos_q;
	assign out_ch.count         = out_count_q;
	assign out_ch.smallest      = out_small_q;

endmodule

// ----- hw/rtl/saq_check.sv -----
`include "sorted_array_search_queue_defines.svh"

module saq_check #(
	parameter int DEPTH = 64,
	parameter int VW    = 32,
	parameter int PW    = 6,
	parameter int CW    = 7
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [1:0]           out_status,
	input logic [PW-1:0]        out_position,
	input logic [CW-1:0]        out_count,
	input logic signed [VW-1:0] out_smallest
);

	`SAQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
	`SAQ_ASSERT_NOW(a_count_max, out_valid, out_count <= CW'(DEPTH), "count above depth")
	`SAQ_ASSERT_NOW(a_empty_cnt, out_valid && out_status == saq_pkg::ST_EMPTY, out_count == '0, "empty status with entries")
	`SAQ_ASSERT_NOW(a_miss_pos, out_valid && out_status == saq_pkg::ST_NOT_FOUND, out_position == '0, "miss with nonzero position")
	`SAQ_ASSERT_NOW(a_empty_min, out_valid && out_count == '0, out_smallest == '0, "empty store with nonzero minimum")

endmodule

bind sorted_array_search_queue saq_check #(
	.DEPTH (DEPTH),
	.VW    (VALUE_WIDTH),
	.PW    ((DEPTH > 1) ? $clog2(DEPTH) : 1),
	.CW    ($clog2(DEPTH + 1))
) u_saq_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_status   (out_ch.status),
	.out_position (out_ch.position),
	.out_count    (out_ch.count),
	.out_smallest (out_ch.smallest)
);
